/* src/bdc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the button debounce counter
package bdc_pkg;

    localparam int NUM_BUTTONS  = 8;
    localparam int NUM_COUNTERS = 8;
    localparam int CNT_W        = 8;
    localparam int TGT_W        = 3;
    localparam int TICKS_W      = 16;
    localparam int BCOUNT_W     = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // action codes
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_TABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd4;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd50;

    typedef logic [NUM_COUNTERS-1:0][CNT_W-1:0] cnt_vec_t;
    typedef logic [NUM_BUTTONS-1:0][CNT_W-1:0]  delta_vec_t;
    typedef logic [NUM_BUTTONS-1:0][TGT_W-1:0]  tgt_vec_t;

    // what one button lane found at window expiry
    typedef struct packed {
        logic             hit;
        logic             changed;
        logic             level;
        logic [TGT_W-1:0] target;
        logic [CNT_W-1:0] delta;
    } lane_res_t;

    typedef lane_res_t [NUM_BUTTONS-1:0] lane_vec_t;

    // one result item
    typedef struct packed {
        cnt_vec_t counter_values;
        logic     state_changed;
        logic     window_busy;
    } out_item_t;

endpackage

/* src/bdc_in_if.sv */
`timescale 1ns / 1ps
// input channel: edge events and timer ticks
interface bdc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [bdc_pkg::NUM_BUTTONS-1:0] edge_mask;
    logic [bdc_pkg::NUM_BUTTONS-1:0] levels;

    modport source (output valid, output action, output edge_mask, output levels,
                    input ready);
    modport sink   (input valid, input action, input edge_mask, input levels,
                    output ready);
endinterface

/* src/bdc_out_if.sv */
`timescale 1ns / 1ps
// output channel: counter snapshot and status
interface bdc_out_if;
    logic              valid;
    logic              ready;
    bdc_pkg::cnt_vec_t counter_values;
    logic              state_changed;
    logic              window_busy;

    modport source (output valid, output counter_values, output state_changed,
                    output window_busy, input ready);
    modport sink   (input valid, input counter_values, input state_changed,
                    input window_busy, output ready);
endinterface

/* src/button_debounce_counter.sv */
`timescale 1ns / 1ps
// top level: debounce window control, button lanes, counter merge, result buffer
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        action, edge_mask, levels
//  out_ch    out  valid/ready        counter_values, state_changed, window_busy
//  cfg       in   cfg_we (no wait)   cfg_index, cfg_data
//
// one item per cycle while in_ch.ready is high; each accepted item yields one result item,
// registered in a two-entry buffer, visible the cycle after acceptance if no older result waits.
// window control, all eight lanes and the counter merge settle in the cycle
// of acceptance, so state is current for the next item.
// in_ch.ready drops only when both buffer entries hold results not yet taken.
// reset clears all state but the buffer payload; debounce_ticks comes up at 50, other registers at 0.
module button_debounce_counter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdc_pkg::CFG_DATA_W-1:0]      cfg_data,
    bdc_in_if.sink                              in_ch,
    bdc_out_if.source                           out_ch
);
    localparam int NB = bdc_pkg::NUM_BUTTONS;

    // configuration registers
    logic [bdc_pkg::BCOUNT_W-1:0] button_count_reg;
    logic [NB-1:0]                invert_mask_reg;
    bdc_pkg::delta_vec_t          delta_table_reg;
    bdc_pkg::tgt_vec_t            target_table_reg;
    logic [bdc_pkg::TICKS_W-1:0]  debounce_ticks_reg;

    // block state
    bdc_pkg::cnt_vec_t            counters_reg, counters_next;
    logic [NB-1:0]                last_levels_reg, last_levels_next;
    logic [NB-1:0]                sample_flags_reg, sample_flags_next;
    logic [NB-1:0]                deferred_flags_reg, deferred_flags_next;
    logic [bdc_pkg::TICKS_W-1:0]  window_count_reg, window_count_next;
    logic                         window_running_reg, window_running_next;

    logic                         fire;
    logic                         expire;
    logic [NB-1:0]                enabled;
    logic [NB-1:0]                edge_hits;
    logic [NB-1:0]                lane_sample;
    logic [NB-1:0]                lane_levels;
    logic [bdc_pkg::TICKS_W-1:0]  start_ticks;
    logic                         buf_space;
    logic                         changed;
    bdc_pkg::lane_vec_t           lanes;
    bdc_pkg::cnt_vec_t            merged;
    bdc_pkg::out_item_t           result;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg   <= '0;
            invert_mask_reg    <= '0;
            delta_table_reg    <= '0;
            target_table_reg   <= '0;
            debounce_ticks_reg <= bdc_pkg::TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdc_pkg::REG_BUTTON_COUNT:
                    button_count_reg <= cfg_data[bdc_pkg::BCOUNT_W-1:0];
                bdc_pkg::REG_INVERT_MASK:
                    invert_mask_reg <= cfg_data[NB-1:0];
                bdc_pkg::REG_DELTA_TABLE:
                    delta_table_reg <= cfg_data[NB*bdc_pkg::CNT_W-1:0];
                bdc_pkg::REG_TARGET_TABLE:
                    target_table_reg <= cfg_data[NB*bdc_pkg::TGT_W-1:0];
                bdc_pkg::REG_DEBOUNCE_TICKS:
                    debounce_ticks_reg <= cfg_data[bdc_pkg::TICKS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // enabled buttons, saturating at the lane count
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            enabled[i] = ({1'b0, button_count_reg} > (bdc_pkg::BCOUNT_W+1)'(i));
        end
    end

    assign in_ch.ready = buf_space;
    assign fire        = in_ch.valid & in_ch.ready;
    assign edge_hits   = in_ch.edge_mask & enabled;
    assign start_ticks = (debounce_ticks_reg == '0) ? bdc_pkg::TICKS_W'(1)
                                                    : debounce_ticks_reg;
    assign expire      = fire & (in_ch.action == bdc_pkg::ACT_TICK) &
                         window_running_reg & (window_count_reg <= bdc_pkg::TICKS_W'(1));
    assign lane_sample = expire ? (sample_flags_reg & enabled) : '0;

    // button lanes
    for (genvar g = 0; g < NB; g++)
    begin : g_lane
        bdc_lane u_lane (
            .sample     (lane_sample[g]),
            .raw_level  (in_ch.levels[g]),
            .invert     (invert_mask_reg[g]),
            .last_level (last_levels_reg[g]),
            .delta      (delta_table_reg[g]),
            .target     (target_table_reg[g]),
            .res        (lanes[g])
        );
        assign lane_levels[g] = lanes[g].level;
    end

    // counter merge
    bdc_merge u_merge (
        .lanes         (lanes),
        .counters      (counters_reg),
        .counters_next (merged),
        .changed       (changed)
    );

    // window control
    always_comb
    begin
        counters_next       = counters_reg;
        last_levels_next    = last_levels_reg;
        sample_flags_next   = sample_flags_reg;
        deferred_flags_next = deferred_flags_reg;
        window_count_next   = window_count_reg;
        window_running_next = window_running_reg;
        if (fire)
        begin
            if (in_ch.action == bdc_pkg::ACT_EDGE)
            begin
                if (edge_hits != '0)
                begin
                    if (!window_running_reg)
                    begin
                        sample_flags_next   = edge_hits;
                        window_count_next   = start_ticks;
                        window_running_next = 1'b1;
                    end
                    else
                    begin
                        sample_flags_next   = sample_flags_reg & ~edge_hits;
                        deferred_flags_next = deferred_flags_reg | edge_hits;
                    end
                end
            end
            else if (window_running_reg)
            begin
                if (!expire)
                begin
                    window_count_next = window_count_reg - bdc_pkg::TICKS_W'(1);
                end
                else
                begin
                    counters_next       = merged;
                    last_levels_next    = lane_levels;
                    window_count_next   = '0;
                    window_running_next = 1'b0;
                    if (deferred_flags_reg != '0)
                    begin
                        sample_flags_next   = deferred_flags_reg;
                        deferred_flags_next = '0;
                        window_count_next   = start_ticks;
                        window_running_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counters_reg       <= '0;
            last_levels_reg    <= '0;
            sample_flags_reg   <= '0;
            deferred_flags_reg <= '0;
            window_count_reg   <= '0;
            window_running_reg <= 1'b0;
        end
        else
        begin
            counters_reg       <= counters_next;
            last_levels_reg    <= last_levels_next;
            sample_flags_reg   <= sample_flags_next;
            deferred_flags_reg <= deferred_flags_next;
            window_count_reg   <= window_count_next;
            window_running_reg <= window_running_next;
        end
    end

    // result item after the update
    always_comb
    begin
        result.counter_values = counters_next;
        result.state_changed  = expire & changed;
        result.window_busy    = window_running_next;
    end

    bdc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_item (result),
        .space     (buf_space),
        .out_ch    (out_ch)
    );
endmodule

/* src/bdc_lane.sv */
`timescale 1ns / 1ps
// one button lane: level qualify, rising detect, delta and target pick
module bdc_lane (
    input  logic                           sample,
    input  logic                           raw_level,
    input  logic                           invert,
    input  logic                           last_level,
    input  logic [bdc_pkg::CNT_W-1:0]      delta,
    input  logic [bdc_pkg::TGT_W-1:0]      target,
    output bdc_pkg::lane_res_t             res
);
    logic level;
    logic rising;

    // qualified level and rising edge
    assign level  = raw_level ^ invert;
    assign rising = sample & level & ~last_level;

    always_comb
    begin
        res.hit     = rising;
        res.changed = rising & (delta != '0);
        res.level   = sample ? level : last_level;
        res.target  = target;
        res.delta   = delta;
    end
endmodule

/* src/bdc_merge.sv */
`timescale 1ns / 1ps
// merge lane results into the counters and the changed flag
module bdc_merge (
    input  bdc_pkg::lane_vec_t lanes,
    input  bdc_pkg::cnt_vec_t  counters,
    output bdc_pkg::cnt_vec_t  counters_next,
    output logic               changed
);
    // per counter, add the deltas of every lane that hit it, mod 256
    always_comb
    begin
        logic [bdc_pkg::CNT_W-1:0] acc;
        for (int c = 0; c < bdc_pkg::NUM_COUNTERS; c++)
        begin
            acc = counters[c];
            for (int b = 0; b < bdc_pkg::NUM_BUTTONS; b++)
            begin
                if (lanes[b].hit &&
                    ({1'b0, lanes[b].target} == (bdc_pkg::TGT_W+1)'(c)))
                begin
                    acc = acc + lanes[b].delta;
                end
            end
            counters_next[c] = acc;
        end
    end

    // any lane applied a nonzero delta
    always_comb
    begin
        changed = 1'b0;
        for (int b = 0; b < bdc_pkg::NUM_BUTTONS; b++)
        begin
            changed = changed | lanes[b].changed;
        end
    end
endmodule

/* src/bdc_out_buf.sv */
`timescale 1ns / 1ps
// two-entry result buffer between the core and the output channel
module bdc_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bdc_pkg::out_item_t push_item,
    output logic               space,
    bdc_out_if.source          out_ch
);
    bdc_pkg::out_item_t mem_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;
    bdc_pkg::out_item_t head;

    assign pop   = out_ch.valid & out_ch.ready;
    assign space = (count_reg != 2'd2);
    assign head  = mem_reg[rd_ptr_reg];

    assign out_ch.valid          = (count_reg != 2'd0);
    assign out_ch.counter_values = head.counter_values;
    assign out_ch.state_changed  = head.state_changed;
    assign out_ch.window_busy    = head.window_busy;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule
